FILE: hdl/ssp_pkg.sv
// ssp_pkg: shared types, constants and helper functions of the sweep sector polygon block
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

	localparam int DEG_TURN = 360;
	localparam int DEG_HALF = 180;
	localparam int DEG_QUARTER = 90;
	localparam int ANGLE_W = 9;
	localparam int RAW_W = 13;
	localparam int COORD_W = 16;
	localparam int SIZE_W = 13;
	localparam int CORNER_W = 7;
	localparam int VTX_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MAX_VTX = 7;
	localparam int SLOT_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SWEEP_CW,
		REG_RECT_LEFT,
		REG_RECT_TOP,
		REG_RECT_WIDTH,
		REG_RECT_HEIGHT,
		REG_CORNER_ANGLE
	} cfg_reg_t;

	typedef struct packed {
		logic                       cw;
		logic signed [COORD_W-1:0]  left;
		logic signed [COORD_W-1:0]  top;
		logic [SIZE_W-1:0]          width;
		logic [SIZE_W-1:0]          height;
		logic [CORNER_W-1:0]        corner;
	} cfg_t;

	typedef struct packed {
		logic signed [VTX_W-1:0] x;
		logic signed [VTX_W-1:0] y;
	} vertex_t;

	// angle of corner id (0..3 for the four corners, in match order)
	function automatic logic [ANGLE_W-1:0] corner_ang(input logic [CORNER_W-1:0] m,
		input logic [1:0] id);
		logic [ANGLE_W-1:0] mm;
		logic [ANGLE_W-1:0] r;
		mm = {2'b00, m};
		case (id)
			2'd0: r = mm;
			2'd1: r = ANGLE_W'(DEG_HALF) - mm;
			2'd2: r = ANGLE_W'(DEG_HALF) + mm;
			2'd3: r = ANGLE_W'(DEG_TURN) - mm;
			default: r = mm;
		endcase
		return r;
	endfunction

	function automatic vertex_t corner_xy(input cfg_t cfg, input logic [1:0] id);
		logic signed [VTX_W-1:0] lx;
		logic signed [VTX_W-1:0] ty;
		logic signed [VTX_W-1:0] wx;
		logic signed [VTX_W-1:0] hy;
		vertex_t v;
		lx = {cfg.left[COORD_W-1], cfg.left};
		ty = {cfg.top[COORD_W-1], cfg.top};
		wx = {{(VTX_W-SIZE_W){1'b0}}, cfg.width};
		hy = {{(VTX_W-SIZE_W){1'b0}}, cfg.height};
		v.x = (id == 2'd0 || id == 2'd3) ? lx + wx : lx;
		v.y = (id == 2'd0 || id == 2'd1) ? ty + hy : ty;
		return v;
	endfunction

	function automatic vertex_t centre_xy(input cfg_t cfg);
		vertex_t v;
		v.x = {cfg.left[COORD_W-1], cfg.left} + {{(VTX_W-SIZE_W+1){1'b0}}, cfg.width[SIZE_W-1:1]};
		v.y = {cfg.top[COORD_W-1], cfg.top} + {{(VTX_W-SIZE_W+1){1'b0}}, cfg.height[SIZE_W-1:1]};
		return v;
	endfunction

	// shift-subtract quotient, used only while building constant tables
	function automatic longint unsigned udiv64(input longint unsigned n,
		input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// tangent or cotangent magnitude of whole degree d (0..89) in q(frac);
	// series sine and cosine in q30, evaluated while building the tables
	function automatic longint unsigned trig_q(input int d, input logic want_cot,
		input int frac);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned ts;
		longint unsigned tc;
		longint unsigned s;
		longint unsigned c;
		longint unsigned num;
		longint unsigned den;
		longint sin_acc;
		longint cos_acc;
		x = udiv64((longint'(d) * 64'd31415926) << 30, 64'd1800000000);
		x2 = (x * x) >> 30;
		ts = x;
		tc = 64'd1 << 30;
		sin_acc = longint'(ts);
		cos_acc = longint'(tc);
		for (int k = 1; k <= 12; k++) begin
			ts = udiv64((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
			tc = udiv64((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
			if (k % 2 == 1) begin
				sin_acc = sin_acc - longint'(ts);
				cos_acc = cos_acc - longint'(tc);
			end else begin
				sin_acc = sin_acc + longint'(ts);
				cos_acc = cos_acc + longint'(tc);
			end
		end
		s = (sin_acc > 0) ? longint'(sin_acc) : 64'd0;
		c = (cos_acc > 0) ? longint'(cos_acc) : 64'd0;
		num = want_cot ? c : s;
		den = want_cot ? s : c;
		if (den == 64'd0)
			return 64'd0;
		return udiv64((num << frac) + (den >> 1), den);
	endfunction

endpackage

`default_nettype wire

FILE: hdl/ssp_sweep_if.sv
// ssp_sweep_if: valid/ready channel carrying one sweep request word
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface ssp_sweep_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] sweep_start;
	logic signed [12:0] sweep_end;

	modport source (output valid, output sweep_start, output sweep_end, input ready);
	modport sink (input valid, input sweep_start, input sweep_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/ssp_vertex_if.sv
// ssp_vertex_if: valid/ready channel carrying one polygon vertex word
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface ssp_vertex_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] vertex_x;
	logic signed [16:0] vertex_y;
	logic               last_vertex;

	modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
		input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
		output ready);
endinterface

`default_nettype wire

FILE: hdl/ssp_edge_lane.sv
// ssp_edge_lane: edge point of one reduced angle, three stages (lookup, multiply, round/add)
// depends on ssp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssp_edge_lane #(
	parameter int TAN_FRACTION_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire ssp_pkg::cfg_t                cfg,
	input  wire logic [ssp_pkg::ANGLE_W-1:0]  angle,
	output ssp_pkg::vertex_t                  vtx
);
	import ssp_pkg::*;

	localparam int F = TAN_FRACTION_BITS;
	localparam int VW = F + 7;
	localparam int PW = VW + SIZE_W + 1;
	localparam int PW1 = PW + 1;
	localparam logic signed [PW:0] RND = PW1'(longint'(1) << F);
	localparam logic signed [PW:0] BIAS = PW1'((longint'(1) << (F + 1)) - 1);
	localparam logic signed [PW:0] VMIN = -PW1'(65536);
	localparam logic signed [PW:0] VMAX = PW1'(65535);

	typedef logic [VW-1:0] tab_t [DEG_QUARTER];
	typedef enum logic [2:0] {K_CORNER, K_RIGHT, K_BOTTOM, K_LEFT, K_TOP} kind_t;

	function automatic tab_t build_tab(input logic want_cot);
		tab_t t;
		for (int i = 0; i < DEG_QUARTER; i++)
			t[i] = VW'(trig_q(i, want_cot, F));
		return t;
	endfunction

	localparam tab_t TAN_TAB = build_tab(1'b0);
	localparam tab_t COT_TAB = build_tab(1'b1);

	// stage 3: classify and look up
	kind_t                 kind_c;
	logic [1:0]            cid_c;
	logic [ANGLE_W-1:0]    c1, c2, c3, c4, m9;
	logic [7:0]            red;
	logic [7:0]            rr;
	logic                  neg;
	logic [6:0]            tix;
	logic [VW-1:0]         mag;
	logic signed [VW-1:0]  val_c;

	always_comb begin
		m9 = {2'b00, cfg.corner};
		c1 = corner_ang(cfg.corner, 2'd0);
		c2 = corner_ang(cfg.corner, 2'd1);
		c3 = corner_ang(cfg.corner, 2'd2);
		c4 = corner_ang(cfg.corner, 2'd3);
		cid_c = 2'd0;
		if (angle == c1) begin
			kind_c = K_CORNER;
		end else if (angle == c2) begin
			kind_c = K_CORNER;
			cid_c = 2'd1;
		end else if (angle == c3) begin
			kind_c = K_CORNER;
			cid_c = 2'd2;
		end else if (angle == c4) begin
			kind_c = K_CORNER;
			cid_c = 2'd3;
		end else if (angle < m9 || angle > c4) begin
			kind_c = K_RIGHT;
		end else if (angle < c2) begin
			kind_c = K_BOTTOM;
		end else if (angle < c3) begin
			kind_c = K_LEFT;
		end else begin
			kind_c = K_TOP;
		end
		// reference angle within the quarter turn
		red = (angle >= ANGLE_W'(DEG_HALF)) ? 8'(angle - ANGLE_W'(DEG_HALF)) : angle[7:0];
		neg = red > 8'(DEG_QUARTER);
		rr = neg ? 8'(DEG_HALF) - red : red;
		tix = (rr == 8'(DEG_QUARTER)) ? 7'd0 : rr[6:0];
		if (rr == 8'(DEG_QUARTER) || kind_c == K_CORNER)
			mag = '0;
		else if (kind_c == K_BOTTOM || kind_c == K_TOP)
			mag = COT_TAB[tix];
		else
			mag = TAN_TAB[tix];
		val_c = neg ? -signed'(mag) : signed'(mag);
	end

	kind_t                kind_s3, kind_s4;
	logic [1:0]           cid_s3, cid_s4;
	logic signed [VW-1:0] val_s3;
	logic signed [PW-1:0] prod_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind_c;
			cid_s3 <= cid_c;
			val_s3 <= val_c;
			kind_s4 <= kind_s3;
			cid_s4 <= cid_s3;
			prod_s4 <= val_s3 * signed'({1'b0,
				(kind_s3 == K_BOTTOM || kind_s3 == K_TOP) ? cfg.height : cfg.width});
		end
	end

	// stage 5: half offset rounded, truncated toward zero, then placed and clamped
	logic signed [PW:0] num;
	logic signed [PW:0] ofs;
	logic signed [PW:0] base;
	logic signed [PW:0] sum;
	vertex_t            ctr;
	vertex_t            crn;
	vertex_t            vtx_c;

	always_comb begin
		num = PW1'(prod_s4) + RND;
		ofs = (num[PW] ? num + BIAS : num) >>> (F + 1);
		ctr = centre_xy(cfg);
		crn = corner_xy(cfg, cid_s4);
		case (kind_s4)
			K_RIGHT, K_LEFT: base = PW1'(ctr.y);
			default: base = PW1'(ctr.x);
		endcase
		sum = (kind_s4 == K_LEFT || kind_s4 == K_TOP) ? base - ofs : base + ofs;
		if (sum < VMIN)
			sum = VMIN;
		else if (sum > VMAX)
			sum = VMAX;
		case (kind_s4)
			K_CORNER: vtx_c = crn;
			K_RIGHT: begin
				vtx_c.x = corner_xy(cfg, 2'd0).x;
				vtx_c.y = sum[VTX_W-1:0];
			end
			K_LEFT: begin
				vtx_c.x = {cfg.left[COORD_W-1], cfg.left};
				vtx_c.y = sum[VTX_W-1:0];
			end
			K_BOTTOM: begin
				vtx_c.x = sum[VTX_W-1:0];
				vtx_c.y = corner_xy(cfg, 2'd0).y;
			end
			default: begin
				vtx_c.x = sum[VTX_W-1:0];
				vtx_c.y = {cfg.top[COORD_W-1], cfg.top};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			vtx <= vtx_c;
	end

endmodule

`default_nettype wire

FILE: hdl/sweep_sector_polygon_top.sv
// sweep_sector_polygon_top: sweep request in, sector polygon vertices out
// depends on ssp_pkg, ssp_sweep_if, ssp_vertex_if, ssp_edge_lane
`timescale 1ns / 1ps
`default_nettype none

//  channel  | dir | word                                   | handshake
//  ---------+-----+----------------------------------------+-----------------
//  sweep    | in  | sweep_start, sweep_end (13b signed)    | valid / ready
//  vertex   | out | vertex_x, vertex_y (17b), last_vertex  | valid / ready
//  cfg      | in  | cfg_index, cfg_data                    | cfg_wr_en only
//
//  five register stages: mod-360 product, mod-360 fix, classify/lookup/order,
//  multiply, round and place; the first vertex word is valid once stage 5 loads the buffer
//  a request fills the vertex buffer with 0, 4 or 3..7 vertex words, one per vertex
//  the whole pipe advances on one enable; it stops while stage 5 holds a request
//  that the vertex buffer cannot take yet, and sweep.ready is that enable
//  reset clears valid bits, buffer state and the config registers to their defaults

module sweep_sector_polygon_top #(
	parameter int TAN_FRACTION_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	ssp_sweep_if.sink                             sweep,
	ssp_vertex_if.source                          vertex,
	input  wire logic                             cfg_wr_en,
	input  wire logic [ssp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ssp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ssp_pkg::*;

	// reciprocal of 360 in q20; the quotient comes out exact or one low
	localparam int RECIP_SH = 20;
	localparam logic [11:0] RECIP = 12'((1 << RECIP_SH) / DEG_TURN);
	localparam logic [13:0] TURN_OFS = 14'(12 * DEG_TURN);

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cw <= 1'b1;
			cfg_q.left <= '0;
			cfg_q.top <= '0;
			cfg_q.width <= SIZE_W'(1);
			cfg_q.height <= SIZE_W'(1);
			cfg_q.corner <= CORNER_W'(45);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_SWEEP_CW: cfg_q.cw <= cfg_data[0];
				REG_RECT_LEFT: cfg_q.left <= cfg_data;
				REG_RECT_TOP: cfg_q.top <= cfg_data;
				REG_RECT_WIDTH: cfg_q.width <= cfg_data[SIZE_W-1:0];
				REG_RECT_HEIGHT: cfg_q.height <= cfg_data[SIZE_W-1:0];
				REG_CORNER_ANGLE: cfg_q.corner <= cfg_data[CORNER_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic en;
	logic load;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;

	assign en = !v5_s5 || load;
	assign sweep.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else if (en) begin
			v1_s1 <= sweep.valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
		end
	end

	// stage 1: shift both angles positive and multiply by the reciprocal
	logic [13:0] pos_c [2];
	logic [13:0] pos_s1 [2];
	logic [25:0] prod_s1 [2];
	logic        raw_eq_s1;

	always_comb begin
		pos_c[0] = 14'(sweep.sweep_start) + TURN_OFS;
		pos_c[1] = 14'(sweep.sweep_end) + TURN_OFS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				pos_s1[i] <= pos_c[i];
				prod_s1[i] <= pos_c[i] * RECIP;
			end
			raw_eq_s1 <= sweep.sweep_start == sweep.sweep_end;
		end
	end

	// stage 2: remainder with one correction step
	logic [13:0]        rem_c [2];
	logic [ANGLE_W-1:0] ang_s2 [2];
	logic               raw_eq_s2;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rem_c[i] = pos_s1[i] - 14'(prod_s1[i][25:RECIP_SH]) * 14'(DEG_TURN);
			if (rem_c[i] >= 14'(DEG_TURN))
				rem_c[i] = rem_c[i] - 14'(DEG_TURN);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s2[0] <= rem_c[0][ANGLE_W-1:0];
			ang_s2[1] <= rem_c[1][ANGLE_W-1:0];
			raw_eq_s2 <= raw_eq_s1;
		end
	end

	// stage 3: which corners lie strictly inside the arc, and in what order
	function automatic logic [ANGLE_W-1:0] arc_dist(input logic cw,
		input logic [ANGLE_W-1:0] from, input logic [ANGLE_W-1:0] to);
		logic signed [ANGLE_W:0] d;
		d = cw ? signed'({1'b0, to}) - signed'({1'b0, from})
		       : signed'({1'b0, from}) - signed'({1'b0, to});
		if (d < 0)
			d = d + (ANGLE_W+1)'(DEG_TURN);
		if (d >= (ANGLE_W+1)'(DEG_TURN))
			d = d - (ANGLE_W+1)'(DEG_TURN);
		return d[ANGLE_W-1:0];
	endfunction

	logic [ANGLE_W-1:0] cang [4];
	logic [ANGLE_W-1:0] cdist [4];
	logic [ANGLE_W-1:0] edist;
	logic [3:0]         incl_c;
	logic [1:0]         rank_c [4];
	logic               cvalid;

	always_comb begin
		edist = arc_dist(cfg_q.cw, ang_s2[0], ang_s2[1]);
		for (int i = 0; i < 4; i++) begin
			cang[i] = corner_ang(cfg_q.corner, 2'(i));
			cdist[i] = arc_dist(cfg_q.cw, ang_s2[0], cang[i]);
		end
		for (int i = 0; i < 4; i++) begin
			// a corner sharing an angle with an earlier one is never emitted
			cvalid = cang[i] != ANGLE_W'(DEG_TURN);
			for (int j = 0; j < i; j++)
				if (cang[j] == cang[i])
					cvalid = 1'b0;
			incl_c[i] = cvalid && cdist[i] != '0 && cdist[i] < edist;
		end
		for (int i = 0; i < 4; i++) begin
			rank_c[i] = 2'd0;
			for (int j = 0; j < 4; j++)
				if (incl_c[j] && cdist[j] < cdist[i])
					rank_c[i] = rank_c[i] + 2'd1;
		end
	end

	logic       raw_eq_s3, raw_eq_s4, raw_eq_s5;
	logic       full_s3, full_s4, full_s5;
	logic [3:0] incl_s3, incl_s4, incl_s5;
	logic [1:0] rank_s3 [4];
	logic [1:0] rank_s4 [4];
	logic [1:0] rank_s5 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			raw_eq_s3 <= raw_eq_s2;
			full_s3 <= ang_s2[0] == ang_s2[1];
			incl_s3 <= incl_c;
			rank_s3 <= rank_c;
			raw_eq_s4 <= raw_eq_s3;
			full_s4 <= full_s3;
			incl_s4 <= incl_s3;
			rank_s4 <= rank_s3;
			raw_eq_s5 <= raw_eq_s4;
			full_s5 <= full_s4;
			incl_s5 <= incl_s4;
			rank_s5 <= rank_s4;
		end
	end

	// stages 3 to 5 of the edge points at the start and end angles
	vertex_t edge_s5 [2];

	ssp_edge_lane #(
		.TAN_FRACTION_BITS(TAN_FRACTION_BITS)
	) u_lane_start (
		.clk(clk),
		.en(en),
		.cfg(cfg_q),
		.angle(ang_s2[0]),
		.vtx(edge_s5[0])
	);

	ssp_edge_lane #(
		.TAN_FRACTION_BITS(TAN_FRACTION_BITS)
	) u_lane_end (
		.clk(clk),
		.en(en),
		.cfg(cfg_q),
		.angle(ang_s2[1]),
		.vtx(edge_s5[1])
	);

	// polygon assembly from stage 5
	vertex_t          slot_c [MAX_VTX];
	logic [SLOT_W-1:0] cnt_c;
	logic [SLOT_W-1:0] ncorner;

	always_comb begin
		for (int k = 0; k < MAX_VTX; k++)
			slot_c[k] = '0;
		ncorner = SLOT_W'($countones(incl_s5));
		if (raw_eq_s5) begin
			cnt_c = '0;
		end else if (full_s5) begin
			// same angle after reduction: the whole rectangle
			for (int i = 0; i < 4; i++)
				slot_c[i] = corner_xy(cfg_q, 2'(i));
			cnt_c = SLOT_W'(4);
		end else begin
			slot_c[0] = centre_xy(cfg_q);
			slot_c[1] = edge_s5[0];
			for (int i = 0; i < 4; i++)
				if (incl_s5[i])
					slot_c[SLOT_W'(2) + SLOT_W'(rank_s5[i])] = corner_xy(cfg_q, 2'(i));
			slot_c[SLOT_W'(2) + ncorner] = edge_s5[1];
			cnt_c = SLOT_W'(3) + ncorner;
		end
	end

	// vertex buffer: one polygon, one vertex word per cycle while vertex.ready is high
	vertex_t           slot_q [MAX_VTX];
	logic [SLOT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] idx_q;
	logic              busy_q;
	logic              last;

	assign last = idx_q == cnt_q - SLOT_W'(1);
	assign load = v5_s5 && (!busy_q || (vertex.ready && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= cnt_c != '0;
			idx_q <= '0;
			cnt_q <= cnt_c;
		end else if (busy_q && vertex.ready) begin
			if (last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			slot_q <= slot_c;
	end

	assign vertex.valid = busy_q;
	assign vertex.vertex_x = slot_q[idx_q].x;
	assign vertex.vertex_y = slot_q[idx_q].y;
	assign vertex.last_vertex = last;

	// a busy buffer never holds an empty polygon
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("vertex buffer busy with no vertices");

	// the read index stays inside the polygon
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < cnt_q)
		else $error("vertex index beyond polygon");

	// a stalled stage 5 request is kept until the buffer takes it
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v5_s5 && !load) |=> (v5_s5 && $stable(incl_s5) && $stable(full_s5)))
		else $error("stage 5 request lost under stall");

endmodule

`default_nettype wire
